// File: hw/rtl/ltkm_pkg.sv
// Shared constants, state codes and request structs for the loser-tree merge selector.
// No dependencies; every other file in hw/rtl imports this package.

package ltkm_pkg;

    localparam int NUM_RUNS = 8;
    localparam int RUN_W    = $clog2(NUM_RUNS);
    localparam int NODE_W   = RUN_W + 1;          // room for the sentinel index
    localparam int KEY_W    = 64;
    localparam int CFG_W    = 4;
    localparam int S_DATA_W = ((RUN_W + KEY_W + 7) / 8) * 8;
    localparam int M_DATA_W = ((RUN_W + KEY_W + 7) / 8) * 8;
    localparam int STATE_W  = 4;

    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(8);

    localparam logic [1:0] MODE_LOAD    = 2'd0;
    localparam logic [1:0] MODE_BUILD   = 2'd1;
    localparam logic [1:0] MODE_NEXT    = 2'd2;
    localparam logic [1:0] MODE_EXHAUST = 2'd3;

    localparam logic [STATE_W-1:0] ST_IDLE    = 4'd0;
    localparam logic [STATE_W-1:0] ST_INIT    = 4'd1;
    localparam logic [STATE_W-1:0] ST_BKEY    = 4'd2;
    localparam logic [STATE_W-1:0] ST_SKEY    = 4'd3;
    localparam logic [STATE_W-1:0] ST_RD_NODE = 4'd4;
    localparam logic [STATE_W-1:0] ST_RD_KEY  = 4'd5;
    localparam logic [STATE_W-1:0] ST_CMP     = 4'd6;
    localparam logic [STATE_W-1:0] ST_OUT_RD  = 4'd7;
    localparam logic [STATE_W-1:0] ST_FIN     = 4'd8;

    typedef struct packed {
        logic             we;
        logic [RUN_W-1:0] waddr;
        logic [KEY_W-1:0] wdata;
        logic             re;
        logic [RUN_W-1:0] raddr;
    } t_key_req;

    typedef struct packed {
        logic              we;
        logic [RUN_W-1:0]  waddr;
        logic [NODE_W-1:0] wdata;
        logic              re;
        logic [RUN_W-1:0]  raddr;
    } t_node_req;

    typedef struct packed {
        logic [RUN_W-1:0] run;
        logic [KEY_W-1:0] key;
        logic             done;
    } t_result;

    // Active run count k, clamped to 2..NUM_RUNS
    function automatic logic [NODE_W-1:0] clamp_k(input logic [CFG_W-1:0] cfg);
        logic [NODE_W-1:0] k;
        if (cfg < CFG_W'(2)) begin
            k = NODE_W'(2);
        end else if (int'(cfg) > NUM_RUNS) begin
            k = NODE_W'(NUM_RUNS);
        end else begin
            k = NODE_W'(cfg);
        end
        return k;
    endfunction

    // First internal node on a leaf's path: (s + k) / 2
    function automatic logic [RUN_W-1:0] start_node(input logic [NODE_W-1:0] s,
                                                    input logic [NODE_W-1:0] k);
        logic [NODE_W:0] sum;
        sum = {1'b0, s} + {1'b0, k};
        return sum[RUN_W:1];
    endfunction

endpackage

// File: hw/rtl/ltkm_key_store.sv
// Leaf key memory: one key per run, one write and one registered read port.
// Depends on ltkm_pkg. Contents are undefined until written.

module ltkm_key_store (
    input  logic                     i_clk,
    input  ltkm_pkg::t_key_req       i_req,
    output logic [ltkm_pkg::KEY_W-1:0] o_q
);
    import ltkm_pkg::*;

    logic [KEY_W-1:0] r_mem [NUM_RUNS];
    logic [KEY_W-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_q <= r_mem[i_req.raddr];
        end
    end

    assign o_q = r_q;

endmodule

// File: hw/rtl/ltkm_node_store.sv
// Loser node memory for internal nodes, registered read, with per-entry valid bits
// so that a node never written since reset reads as zero. Depends on ltkm_pkg.

module ltkm_node_store (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  ltkm_pkg::t_node_req         i_req,
    output logic [ltkm_pkg::NODE_W-1:0] o_q
);
    import ltkm_pkg::*;

    logic [NODE_W-1:0]   r_mem [NUM_RUNS];
    logic [NUM_RUNS-1:0] r_val;
    logic [NODE_W-1:0]   r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_val <= '0;
        end else if (i_req.we) begin
            r_val[i_req.waddr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_q <= r_val[i_req.raddr] ? r_mem[i_req.raddr] : '0;
        end
    end

    assign o_q = r_q;

endmodule

// File: hw/rtl/ltkm_ctrl.sv
// Sequencer for the loser tree: leaf loads, tree build and leaf-to-root replay.
// Holds the exhausted flags and the root winner. Depends on ltkm_pkg.

module ltkm_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [ltkm_pkg::NODE_W-1:0] i_k,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [1:0]                  i_mode,
    input  logic [ltkm_pkg::RUN_W-1:0]  i_run_index,
    input  logic [ltkm_pkg::KEY_W-1:0]  i_key,
    output ltkm_pkg::t_key_req          o_key_req,
    input  logic [ltkm_pkg::KEY_W-1:0]  i_key_q,
    output ltkm_pkg::t_node_req         o_node_req,
    input  logic [ltkm_pkg::NODE_W-1:0] i_node_q,
    output logic                        o_res_valid,
    input  logic                        i_res_ready,
    output ltkm_pkg::t_result           o_res
);
    import ltkm_pkg::*;

    logic [STATE_W-1:0]  r_state;
    logic [NODE_W-1:0]   r_s;       // climbing leaf
    logic [KEY_W-1:0]    r_skey;    // its key
    logic [NODE_W-1:0]   r_held;    // loser stored at the current node
    logic [RUN_W-1:0]    r_node;
    logic [RUN_W-1:0]    r_leaf;    // build: leaf being inserted
    logic                r_build;
    logic [NODE_W-1:0]   r_win;     // node 0
    logic [NUM_RUNS-1:0] r_exh;

    logic              w_accept;
    logic              w_win_ok;
    logic              w_yield;
    logic              w_exs;
    logic              w_ext;
    logic [NODE_W-1:0] w_k_m1;
    logic [NODE_W-1:0] w_next_s;

    assign w_accept = i_in_valid && (r_state == ST_IDLE);
    assign o_in_ready = (r_state == ST_IDLE);
    assign w_win_ok = (r_win < i_k) && !r_exh[r_win[RUN_W-1:0]];
    assign w_k_m1   = i_k - NODE_W'(1);
    assign w_exs    = r_exh[r_s[RUN_W-1:0]];
    assign w_ext    = r_exh[r_held[RUN_W-1:0]];

    // Climbing leaf yields to the stored loser; ties keep the climber
    always_comb begin
        if (r_s >= i_k) begin
            w_yield = 1'b0;
        end else if (r_held >= i_k) begin
            w_yield = 1'b1;
        end else if (w_exs != w_ext) begin
            w_yield = w_exs;
        end else if (w_exs) begin
            w_yield = 1'b0;
        end else begin
            w_yield = $signed(r_skey) > $signed(i_key_q);
        end
    end

    assign w_next_s = w_yield ? r_held : r_s;

    always_comb begin
        o_key_req       = '0;
        o_key_req.wdata = i_key;
        o_key_req.waddr = (i_mode == MODE_LOAD) ? i_run_index : r_win[RUN_W-1:0];
        o_key_req.we    = w_accept && ((i_mode == MODE_LOAD)
                                       || ((i_mode == MODE_NEXT) && w_win_ok));
        case (r_state)
            ST_BKEY: begin
                o_key_req.re    = 1'b1;
                o_key_req.raddr = r_leaf;
            end
            ST_RD_KEY: begin
                o_key_req.re    = 1'b1;
                o_key_req.raddr = i_node_q[RUN_W-1:0];
            end
            ST_OUT_RD: begin
                o_key_req.re    = 1'b1;
                o_key_req.raddr = r_win[RUN_W-1:0];
            end
            default: begin
                o_key_req.re    = 1'b0;
                o_key_req.raddr = r_leaf;
            end
        endcase
    end

    always_comb begin
        o_node_req       = '0;
        o_node_req.waddr = r_node;
        o_node_req.raddr = r_node;
        o_node_req.re    = (r_state == ST_RD_NODE);
        case (r_state)
            ST_INIT: begin
                o_node_req.we    = 1'b1;
                o_node_req.wdata = i_k;
            end
            ST_CMP: begin
                o_node_req.we    = w_yield;
                o_node_req.wdata = r_s;
            end
            default: begin
                o_node_req.we    = 1'b0;
                o_node_req.wdata = r_s;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_s     <= '0;
            r_skey  <= '0;
            r_held  <= '0;
            r_node  <= '0;
            r_leaf  <= '0;
            r_build <= 1'b0;
            r_win   <= '0;
            r_exh   <= '0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        case (i_mode)
                            MODE_LOAD: begin
                                r_exh[i_run_index] <= 1'b0;
                            end
                            MODE_BUILD: begin
                                r_build <= 1'b1;
                                r_node  <= RUN_W'(1);
                                r_state <= ST_INIT;
                            end
                            MODE_NEXT: begin
                                if (w_win_ok) begin
                                    r_build <= 1'b0;
                                    r_s     <= r_win;
                                    r_skey  <= i_key;
                                    r_node  <= start_node(r_win, i_k);
                                    r_state <= ST_RD_NODE;
                                end else begin
                                    r_state <= ST_FIN;
                                end
                            end
                            MODE_EXHAUST: begin
                                // exhausted climber never needs its key
                                if (w_win_ok) begin
                                    r_build <= 1'b0;
                                    r_exh[r_win[RUN_W-1:0]] <= 1'b1;
                                    r_s     <= r_win;
                                    r_node  <= start_node(r_win, i_k);
                                    r_state <= ST_RD_NODE;
                                end else begin
                                    r_state <= ST_FIN;
                                end
                            end
                            default: begin
                                r_state <= ST_IDLE;
                            end
                        endcase
                    end
                end
                ST_INIT: begin
                    // fill nodes 1..k-1 with the sentinel
                    if ({1'b0, r_node} >= w_k_m1) begin
                        r_leaf  <= w_k_m1[RUN_W-1:0];
                        r_state <= ST_BKEY;
                    end else begin
                        r_node <= r_node + RUN_W'(1);
                    end
                end
                ST_BKEY: begin
                    r_s     <= {1'b0, r_leaf};
                    r_node  <= start_node({1'b0, r_leaf}, i_k);
                    r_state <= ST_SKEY;
                end
                ST_SKEY: begin
                    r_skey  <= i_key_q;
                    r_state <= ST_RD_NODE;
                end
                ST_RD_NODE: begin
                    r_state <= ST_RD_KEY;
                end
                ST_RD_KEY: begin
                    r_held  <= i_node_q;
                    r_state <= ST_CMP;
                end
                ST_CMP: begin
                    if (w_yield) begin
                        r_s    <= r_held;
                        r_skey <= i_key_q;
                    end
                    if (r_node == RUN_W'(1)) begin
                        r_win <= w_next_s;
                        if (r_build && (r_leaf != '0)) begin
                            r_leaf  <= r_leaf - RUN_W'(1);
                            r_state <= ST_BKEY;
                        end else begin
                            r_state <= ST_OUT_RD;
                        end
                    end else begin
                        r_node  <= r_node >> 1;
                        r_state <= ST_RD_NODE;
                    end
                end
                ST_OUT_RD: begin
                    r_state <= ST_FIN;
                end
                ST_FIN: begin
                    if (i_res_ready) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_res_valid = (r_state == ST_FIN);
    assign o_res.run   = w_win_ok ? r_win[RUN_W-1:0] : '0;
    assign o_res.key   = w_win_ok ? i_key_q : '0;
    assign o_res.done  = !w_win_ok;

endmodule

// File: hw/rtl/loser_tree_kway_merge.sv
// Loser-tree selector for a k-way merge: top level with config register and result register.
// Depends on ltkm_pkg, ltkm_key_store, ltkm_node_store and ltkm_ctrl.
//
// Usage:
//   Input stream: tuser = mode (0 load leaf, 1 build, 2 next key for winner,
//   3 winner exhausted); tdata = run_index then key. Mode 0 gives no result;
//   modes 1..3 give one result item: tdata = winner_run then winner_key,
//   tuser = all_done (run and key are zero when all_done is set).
//   Config channel writes runs_in_use (clamped to 2..8); write only while idle.
//   Replay: one climb passes L = floor(log2(s + k)) levels, each a node read,
//   a key read, then a compare and write; modes 2 and 3 replay the winner's leaf
//   while it is valid. A build fills nodes 1..k-1 with the sentinel, then replays
//   every leaf from k - 1 down to 0. Each level waits on two registered memory reads.
//   The result sits in an output register; a stalled receiver holds it there
//   while the next item is accepted, and the sequencer waits only when a new
//   result is ready and the register is still full.
//   Reset: synchronous, active low; clears exhausted flags and loser nodes,
//   makes run 0 the winner and sets runs_in_use to 8. Leaf keys stay undefined
//   until loaded.

module loser_tree_kway_merge (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [ltkm_pkg::CFG_W-1:0]    i_cfg_data,      // runs_in_use
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    input  logic [ltkm_pkg::S_DATA_W-1:0] i_s_axis_tdata,  // run_index, key, zero pad
    input  logic [1:0]                    i_s_axis_tuser,  // mode
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    output logic [ltkm_pkg::M_DATA_W-1:0] o_m_axis_tdata,  // winner_run, winner_key, zero pad
    output logic                          o_m_axis_tuser   // all_done
);
    import ltkm_pkg::*;

    logic [CFG_W-1:0] r_cfg;
    logic             r_out_valid;
    t_result          r_out;

    t_key_req          w_key_req;
    t_node_req         w_node_req;
    logic [KEY_W-1:0]  w_key_q;
    logic [NODE_W-1:0] w_node_q;
    logic              w_res_valid;
    logic              w_res_ready;
    t_result           w_res;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_valid) begin
            r_cfg <= i_cfg_data;
        end
    end

    ltkm_key_store u_keys (
        .i_clk (i_clk),
        .i_req (w_key_req),
        .o_q   (w_key_q)
    );

    ltkm_node_store u_nodes (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_node_req),
        .o_q     (w_node_q)
    );

    ltkm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_k         (clamp_k(r_cfg)),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .i_mode      (i_s_axis_tuser),
        .i_run_index (i_s_axis_tdata[RUN_W-1:0]),
        .i_key       (i_s_axis_tdata[RUN_W+KEY_W-1:RUN_W]),
        .o_key_req   (w_key_req),
        .i_key_q     (w_key_q),
        .o_node_req  (w_node_req),
        .i_node_q    (w_node_q),
        .o_res_valid (w_res_valid),
        .i_res_ready (w_res_ready),
        .o_res       (w_res)
    );

    assign w_res_ready = !r_out_valid || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_valid && w_res_ready) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_valid && w_res_ready) begin
            r_out <= w_res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = M_DATA_W'({r_out.key, r_out.run});
    assign o_m_axis_tuser  = r_out.done;

endmodule

// File: hw/rtl/ltkm_checker.sv
// Port-level assertions for the loser-tree merge selector, bound to the top level.
// Depends on ltkm_pkg and loser_tree_kway_merge.

module ltkm_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_s_axis_tvalid,
    input logic                          o_s_axis_tready,
    input logic [1:0]                    i_s_axis_tuser,
    input logic                          o_m_axis_tvalid,
    input logic                          i_m_axis_tready,
    input logic [ltkm_pkg::M_DATA_W-1:0] o_m_axis_tdata,
    input logic                          o_m_axis_tuser
);
    import ltkm_pkg::*;

    logic w_in_acc;
    assign w_in_acc = i_s_axis_tvalid && o_s_axis_tready;

    // no result survives a reset
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("result changed while stalled");

    // when every run is done, winner fields read zero
    a_done_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser |-> o_m_axis_tdata == '0)
        else $error("all_done result carries data");

    // a leaf load produces no result
    a_load_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc && (i_s_axis_tuser == MODE_LOAD) && !o_m_axis_tvalid
            |=> !o_m_axis_tvalid)
        else $error("leaf load produced a result");

    // tree work is sequential: no second item right behind a build or replay
    a_busy_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc && (i_s_axis_tuser != MODE_LOAD) |=> !o_s_axis_tready)
        else $error("item accepted while tree busy");

endmodule

bind loser_tree_kway_merge ltkm_checker u_ltkm_checker (.*);

// File: dv/tb.sv
// Self-checking testbench for loser_tree_kway_merge: directed and random merge traffic.
// Depends on ltkm_pkg and the RTL under hw/rtl; a scoreboard class predicts every result.

module tb;
    import ltkm_pkg::*;

    localparam int              SETTLE_CYCLES = 32;
    localparam int              TAIL_CYCLES   = 64;
    localparam int              HOLD_CYCLES   = 400;
    localparam int              BATCH_ITEMS   = 115;
    localparam int              TOTAL_ITEMS   = 1375;
    localparam longint          RUN_LIMIT     = 64'd12_000_000;
    localparam logic [KEY_W-1:0] KEY_MIN      = {1'b1, {(KEY_W-1){1'b0}}};
    localparam logic [KEY_W-1:0] KEY_MAX      = {1'b0, {(KEY_W-1){1'b1}}};

    logic                i_clk           = 1'b0;
    logic                i_rst_n         = 1'b0;
    logic                i_cfg_valid     = 1'b0;
    logic                o_cfg_ready;
    logic [CFG_W-1:0]    i_cfg_data      = CFG_RESET;
    logic                i_s_axis_tvalid = 1'b0;
    logic                o_s_axis_tready;
    logic [S_DATA_W-1:0] i_s_axis_tdata  = '0;    // run_index, key, zero pad
    logic [1:0]          i_s_axis_tuser  = MODE_LOAD; // mode
    logic                o_m_axis_tvalid;
    logic                i_m_axis_tready = 1'b0;
    logic [M_DATA_W-1:0] o_m_axis_tdata;          // winner_run, winner_key, zero pad
    logic                o_m_axis_tuser;          // all_done

    int unsigned src_idle_pct  = 0;
    int unsigned snk_stall_pct = 0;
    bit          hold_req      = 1'b0;
    logic        hold_active   = 1'b0;
    int          cfg_writes    = 0;

    loser_tree_kway_merge uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    class merge_scoreboard;
        logic [KEY_W-1:0]  leaf_key  [NUM_RUNS];
        bit                leaf_dead [NUM_RUNS];
        logic [NODE_W-1:0] tree      [NUM_RUNS];
        logic [CFG_W-1:0]  run_count;
        t_result           winners_due [$];
        int                errors;
        int                items_seen;
        int                results_seen;
        int                done_seen;
        int                builds_seen;

        function new();
            for (int i = 0; i < NUM_RUNS; i++) begin
                leaf_key[i]  = '0;
                leaf_dead[i] = 1'b0;
                tree[i]      = '0;
            end
            run_count    = CFG_RESET;
            errors       = 0;
            items_seen   = 0;
            results_seen = 0;
            done_seen    = 0;
            builds_seen  = 0;
        endfunction

        function void report(string msg);
            $display("MISMATCH @%0t: %s", $time, msg);
            errors++;
        endfunction

        function void set_runs(logic [CFG_W-1:0] v);
            run_count = v;
        endfunction

        function int unsigned active_runs();
            if (run_count < 2) return 2;
            if (run_count > NUM_RUNS) return NUM_RUNS;
            return 32'(run_count);
        endfunction

        // climbing leaf s gives way to the stored leaf t
        function bit gives_way(int unsigned s, int unsigned t, int unsigned k);
            if (s >= k) return 1'b0;
            if (t >= k) return 1'b1;
            if (leaf_dead[s] != leaf_dead[t]) return leaf_dead[s];
            if (leaf_dead[s]) return 1'b0;
            return $signed(leaf_key[s]) > $signed(leaf_key[t]);
        endfunction

        function void climb(int unsigned s, int unsigned k);
            int unsigned node;
            int unsigned held;
            node = (s + k) / 2;
            while (node > 0) begin
                held = 32'(tree[node]);
                if (gives_way(s, held, k)) begin
                    tree[node] = NODE_W'(s);
                    s = held;
                end
                node = node / 2;
            end
            tree[0] = NODE_W'(s);
        endfunction

        function bit winner_ok();
            int unsigned q;
            q = 32'(tree[0]);
            if (q >= active_runs()) return 1'b0;
            return !leaf_dead[q];
        endfunction

        function logic [KEY_W-1:0] winner_key();
            return leaf_key[tree[0][RUN_W-1:0]];
        endfunction

        function logic [RUN_W-1:0] winner_run();
            return tree[0][RUN_W-1:0];
        endfunction

        function int pending();
            return winners_due.size();
        endfunction

        function void note_input(logic [1:0] mode, logic [RUN_W-1:0] idx,
                                 logic [KEY_W-1:0] key);
            int unsigned k;
            int unsigned q;
            t_result     exp_res;
            k = active_runs();
            items_seen++;
            if (mode == MODE_LOAD) begin
                leaf_key[idx]  = key;
                leaf_dead[idx] = 1'b0;
                return;
            end
            if (mode == MODE_BUILD) begin
                builds_seen++;
                for (int i = 0; i < k; i++) tree[i] = NODE_W'(k);
                for (int i = k; i > 0; i--) climb(i - 1, k);
            end else if (winner_ok()) begin
                q = 32'(tree[0]);
                if (mode == MODE_NEXT) leaf_key[q] = key;
                else leaf_dead[q] = 1'b1;
                climb(q, k);
            end
            if (winner_ok()) begin
                exp_res.run  = tree[0][RUN_W-1:0];
                exp_res.key  = leaf_key[tree[0][RUN_W-1:0]];
                exp_res.done = 1'b0;
            end else begin
                exp_res.run  = '0;
                exp_res.key  = '0;
                exp_res.done = 1'b1;
            end
            winners_due.push_back(exp_res);
        endfunction

        function void check_result(logic [M_DATA_W-1:0] data, logic flag);
            t_result exp_res;
            logic [RUN_W-1:0] got_run;
            logic [KEY_W-1:0] got_key;
            got_run = data[RUN_W-1:0];
            got_key = data[RUN_W +: KEY_W];
            results_seen++;
            if (winners_due.size() == 0) begin
                report($sformatf("unexpected item run=%0d key=%h done=%b",
                                 got_run, got_key, flag));
                return;
            end
            exp_res = winners_due.pop_front();
            if (flag !== exp_res.done)
                report($sformatf("all_done got %b exp %b", flag, exp_res.done));
            if (got_run !== exp_res.run)
                report($sformatf("winner_run got %0d exp %0d", got_run, exp_res.run));
            if (got_key !== exp_res.key)
                report($sformatf("winner_key got %h exp %h", got_key, exp_res.key));
            if (exp_res.done) done_seen++;
        endfunction
    endclass

    merge_scoreboard sb;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // receiver: random stalls plus the long hold-off
    always @(posedge i_clk) begin
        i_m_axis_tready <= !hold_active && ($urandom_range(99) >= snk_stall_pct);
    end

    initial begin
        wait (hold_req);
        @(posedge i_clk);
        hold_active <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_active <= 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid === 1'b1 && i_m_axis_tready)
            sb.check_result(o_m_axis_tdata, o_m_axis_tuser);
    end

    initial begin
        #(RUN_LIMIT);
        $display("Timeout waiting for the block");
        $display("Regression FAIL");
        $finish;
    end

    // Offers one item and returns at the edge it is accepted; tvalid stays up
    // so a back-to-back item can follow in the same step.
    task automatic send_item(input logic [1:0] mode, input logic [RUN_W-1:0] idx,
                             input logic [KEY_W-1:0] key);
        while ($urandom_range(99) < src_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= S_DATA_W'({key, idx});
        i_s_axis_tuser  <= mode;
        @(posedge i_clk);
        while (o_s_axis_tready !== 1'b1) @(posedge i_clk);
        sb.note_input(mode, idx, key);
    endtask

    task automatic wait_drained();
        i_s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    task automatic write_runs(input logic [CFG_W-1:0] v);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        @(posedge i_clk);
        while (o_cfg_ready !== 1'b1) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        sb.set_runs(v);
        cfg_writes++;
    endtask

    function automatic logic [KEY_W-1:0] pick_key();
        logic signed [KEY_W-1:0] v;
        case ($urandom_range(9))
            0: v = KEY_MIN;
            1: v = KEY_MAX;
            2, 3: begin
                v = KEY_W'($urandom_range(16));
                v = v - 8;
            end
            default: v = {$urandom, $urandom};
        endcase
        return v;
    endfunction

    // next key of a sorted run: never below the current head
    function automatic logic [KEY_W-1:0] next_sorted(input logic [KEY_W-1:0] head);
        logic signed [KEY_W-1:0] base;
        logic signed [KEY_W-1:0] v;
        logic        [KEY_W-1:0] delta;
        base = head;
        case ($urandom_range(9))
            0, 1:    delta = '0;
            2:       delta = KEY_MAX;
            3, 4, 5: delta = KEY_W'($urandom_range(16, 1));
            default: delta = KEY_W'($urandom);
        endcase
        v = base + $signed(delta);
        if (v < base) v = KEY_MAX;
        return v;
    endfunction

    task automatic run_merge();
        int unsigned k;
        int unsigned pick;
        int          steps;
        k = sb.active_runs();
        for (int i = 0; i < k; i++)
            send_item(MODE_LOAD, RUN_W'(i), pick_key());
        if ($urandom_range(3) == 0)
            send_item(MODE_LOAD, RUN_W'($urandom_range(NUM_RUNS - 1)), pick_key());
        send_item(MODE_BUILD, RUN_W'($urandom), pick_key());
        steps = 0;
        while (sb.winner_ok() && steps < 80) begin
            pick = $urandom_range(99);
            if (pick < 16)
                send_item(MODE_EXHAUST, RUN_W'($urandom), pick_key());
            else if (pick < 82)
                send_item(MODE_NEXT, RUN_W'($urandom), next_sorted(sb.winner_key()));
            else if (pick < 91)
                send_item(MODE_NEXT, RUN_W'($urandom), pick_key());
            else if (pick < 96)
                send_item(MODE_LOAD, RUN_W'($urandom), pick_key());
            else
                send_item(2'($urandom), RUN_W'($urandom), pick_key());
            steps++;
        end
        // poke the finished tree now and then
        if ($urandom_range(2) == 0)
            send_item($urandom_range(1) ? MODE_NEXT : MODE_EXHAUST, RUN_W'($urandom),
                      pick_key());
    endtask

    logic [KEY_W-1:0] seed_keys [NUM_RUNS];
    logic [CFG_W-1:0] run_settings [11];
    logic [RUN_W-1:0] last_win;
    int               batch;

    initial begin
        sb = new();
        seed_keys = '{KEY_MIN, KEY_MAX, 64'd0, {KEY_W{1'b1}}, 64'd5, 64'd5,
                      KEY_MAX, KEY_MIN};
        run_settings = '{4'd8, 4'd2, 4'd15, 4'd5, 4'd0, 4'd3, 4'd9, 4'd1, 4'd7,
                         4'd4, 4'd6};
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extreme and tied keys, every mode, run exhaustion to the end
        for (int i = 0; i < NUM_RUNS; i++)
            send_item(MODE_LOAD, RUN_W'(i), seed_keys[i]);
        send_item(MODE_BUILD, 3'd7, KEY_MAX);
        send_item(MODE_NEXT, 3'd0, KEY_MAX);
        last_win = sb.winner_run();
        send_item(MODE_EXHAUST, 3'd5, KEY_MIN);
        send_item(MODE_LOAD, last_win, KEY_MIN);  // reload clears the exhausted flag
        send_item(MODE_BUILD, 3'd0, 64'd0);
        for (int i = 0; i < NUM_RUNS; i++)
            send_item(MODE_EXHAUST, RUN_W'(i), {KEY_W{1'b1}});
        send_item(MODE_NEXT, 3'd2, 64'd1);        // no winner left: no change
        send_item(MODE_EXHAUST, 3'd6, KEY_MAX);

        batch = 0;
        while (sb.items_seen < TOTAL_ITEMS) begin
            write_runs(run_settings[batch % 11]);
            case (batch % 4)
                0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
                1: begin src_idle_pct = 46; snk_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  snk_stall_pct = 46; end
                default: begin src_idle_pct = 19; snk_stall_pct = 19; end
            endcase
            if (batch == 4) hold_req = 1'b1;
            // stale tree after a change of run count
            repeat ($urandom_range(2))
                send_item($urandom_range(1) ? MODE_NEXT : MODE_EXHAUST,
                          RUN_W'($urandom), pick_key());
            while (sb.items_seen < BATCH_ITEMS * (batch + 1) && sb.items_seen < TOTAL_ITEMS)
                run_merge();
            batch++;
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("Run covered %0d items, %0d results (%0d with every run exhausted),",
                 sb.items_seen, sb.results_seen, sb.done_seen);
        $display("%0d tree builds, %0d run-count writes, four idle profiles, one long stall.",
                 sb.builds_seen, cfg_writes);
        if (sb.errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("%0d mismatches", sb.errors);
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// File: loser_tree_kway_merge.f
hw/rtl/ltkm_pkg.sv
hw/rtl/ltkm_key_store.sv
hw/rtl/ltkm_node_store.sv
hw/rtl/ltkm_ctrl.sv
hw/rtl/loser_tree_kway_merge.sv
hw/rtl/ltkm_checker.sv
dv/tb.sv
